### rtl/pwe_pkg.sv
// Shared constants, types and codes for the piecewise polynomial evaluator.
`default_nettype none

package pwe_pkg;

   localparam int NUM_INTERVALS = 35;
   localparam int NUM_COEFFS    = 6;

   localparam int FRAC_W     = 24;
   localparam int COEFF_W    = 48;
   localparam int ARG_W      = 25;
   localparam int INTERVAL_W = 6;
   localparam int POWER_W    = 3;

   localparam int ROW_AW  = (NUM_INTERVALS > 1) ? $clog2(NUM_INTERVALS) : 1;
   localparam int LANE_W  = $clog2(NUM_COEFFS);
   localparam int ACC_W   = COEFF_W + 1 + $clog2(NUM_COEFFS);
   localparam int HI_W    = COEFF_W - FRAC_W + ARG_W + 1;
   localparam int LO_W    = ARG_W;
   localparam int IDX_PROD_W = ARG_W + $clog2(NUM_INTERVALS + 1);
   localparam int IDX_RAW_W  = IDX_PROD_W - FRAC_W;

   localparam logic [ARG_W-1:0] ARG_ONE = ARG_W'(1) << FRAC_W;

   localparam logic signed [ACC_W-1:0] ACC_VALUE_MAX =
      (ACC_W'(1) << (COEFF_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ACC_VALUE_MIN = ~ACC_VALUE_MAX;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_EVAL = 1'b1
   } req_kind_type;

   typedef logic [NUM_COEFFS-1:0][COEFF_W-1:0] coeff_row_type;

   typedef struct packed {
      logic              valid;
      logic [ROW_AW-1:0] sel;
      logic [ARG_W-1:0]  x;
   } issue_type;

   typedef struct packed {
      logic signed [COEFF_W-1:0] value;
      logic [INTERVAL_W-1:0]     interval;
      logic                      saturated;
   } result_type;

endpackage

`default_nettype wire

### rtl/pwe_coeff_mem.sv
// Coefficient table: one row per interval, written one coefficient at a time, read a row at once.
`default_nettype none

module pwe_coeff_mem (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [pwe_pkg::ROW_AW-1:0]      wr_row,
   input  wire logic [pwe_pkg::LANE_W-1:0]      wr_lane,
   input  wire logic [pwe_pkg::COEFF_W-1:0]     wr_data,
   input  wire logic                            rd_en,
   input  wire logic [pwe_pkg::ROW_AW-1:0]      rd_row,
   output pwe_pkg::coeff_row_type               rd_data
);

   logic [pwe_pkg::COEFF_W-1:0] mem_ff [pwe_pkg::NUM_INTERVALS][pwe_pkg::NUM_COEFFS];
   pwe_pkg::coeff_row_type      rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row][wr_lane] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int l = 0; l < pwe_pkg::NUM_COEFFS; l++) begin
            rd_data_ff[l] <= mem_ff[rd_row][l];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/pwe_eval_pipe.sv
// Evaluation pipeline: power chain, split coefficient products, accumulation and saturation.
`default_nettype none

module pwe_eval_pipe (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  pwe_pkg::issue_type          issue,
   output logic                        issue_ready,
   input  pwe_pkg::coeff_row_type      row_data,
   output logic                        res_valid,
   input  wire logic                   res_stall,
   output pwe_pkg::result_type         res
);

   localparam int NC   = pwe_pkg::NUM_COEFFS;
   localparam int LAST = NC + 2;

   // Stage k (1..NC-1) forms term k; stage NC+1 holds the sum; stage NC+2 is the output.
   logic v_ff  [1:LAST];
   logic ready [1:LAST];

   logic [pwe_pkg::ARG_W-1:0]         x_ff   [1:NC];
   logic [pwe_pkg::ROW_AW-1:0]        sel_ff [1:NC+1];
   logic [pwe_pkg::ARG_W-1:0]         pw_ff  [2:NC];
   pwe_pkg::coeff_row_type            row_ff [2:NC];
   logic signed [pwe_pkg::ACC_W-1:0]  acc_ff [2:NC];
   logic signed [pwe_pkg::HI_W-1:0]   hi_ff  [2:NC];
   logic [pwe_pkg::LO_W-1:0]          lo_ff  [2:NC];
   logic signed [pwe_pkg::ACC_W-1:0]  sum_ff;
   pwe_pkg::result_type               res_ff;

   pwe_pkg::coeff_row_type            st_row [1:NC];
   logic [pwe_pkg::ARG_W-1:0]         st_pw  [1:NC];
   logic signed [pwe_pkg::ACC_W-1:0]  st_acc [1:NC];
   logic signed [pwe_pkg::HI_W-1:0]   st_hi  [1:NC];
   logic [pwe_pkg::LO_W-1:0]          st_lo  [1:NC];

   logic signed [pwe_pkg::ACC_W-1:0]  acc_in [1:NC];
   logic signed [pwe_pkg::HI_W-1:0]   hi_in  [1:NC];
   logic [pwe_pkg::LO_W-1:0]          lo_in  [1:NC];
   logic [pwe_pkg::ARG_W-1:0]         pw_in  [1:NC];

   logic [pwe_pkg::FRAC_W+pwe_pkg::ARG_W-1:0] lo_prod [1:NC];
   logic [2*pwe_pkg::ARG_W-1:0]               pw_prod [1:NC];

   pwe_pkg::result_type               res_in;

   // A stage may load when it is empty or its word moves on in the same cycle.
   always_comb begin
      ready[LAST] = !v_ff[LAST] || !res_stall;
      for (int k = LAST - 1; k >= 1; k--) begin
         ready[k] = !v_ff[k] || ready[k+1];
      end
   end

   assign issue_ready = ready[1];

   always_comb begin
      for (int k = 1; k <= NC; k++) begin
         if (k == 1) begin
            st_row[k] = row_data;
            st_pw[k]  = x_ff[1];
            st_acc[k] = pwe_pkg::ACC_W'($signed(row_data[0]));
            st_hi[k]  = '0;
            st_lo[k]  = '0;
         end else begin
            st_row[k] = row_ff[k];
            st_pw[k]  = pw_ff[k];
            st_acc[k] = acc_ff[k];
            st_hi[k]  = hi_ff[k];
            st_lo[k]  = lo_ff[k];
         end

         acc_in[k] = st_acc[k] + pwe_pkg::ACC_W'(st_hi[k])
                     + pwe_pkg::ACC_W'(st_lo[k]);

         if (k < NC) begin
            // floor(c*p/2^24) split as upper half times p plus floored lower half times p.
            hi_in[k]   = $signed(st_row[k][k][pwe_pkg::COEFF_W-1:pwe_pkg::FRAC_W])
                         * $signed({1'b0, st_pw[k]});
            lo_prod[k] = st_row[k][k][pwe_pkg::FRAC_W-1:0] * st_pw[k];
            lo_in[k]   = lo_prod[k][pwe_pkg::FRAC_W+pwe_pkg::ARG_W-1:pwe_pkg::FRAC_W];
            pw_prod[k] = st_pw[k] * x_ff[k];
            pw_in[k]   = pw_prod[k][pwe_pkg::FRAC_W+pwe_pkg::ARG_W-1:pwe_pkg::FRAC_W];
         end else begin
            hi_in[k]   = '0;
            lo_prod[k] = '0;
            lo_in[k]   = '0;
            pw_prod[k] = '0;
            pw_in[k]   = '0;
         end
      end
   end

   always_comb begin
      res_in.interval = pwe_pkg::INTERVAL_W'(sel_ff[NC+1]);
      if (sum_ff > pwe_pkg::ACC_VALUE_MAX) begin
         res_in.value     = pwe_pkg::ACC_VALUE_MAX[pwe_pkg::COEFF_W-1:0];
         res_in.saturated = 1'b1;
      end else if (sum_ff < pwe_pkg::ACC_VALUE_MIN) begin
         res_in.value     = pwe_pkg::ACC_VALUE_MIN[pwe_pkg::COEFF_W-1:0];
         res_in.saturated = 1'b1;
      end else begin
         res_in.value     = sum_ff[pwe_pkg::COEFF_W-1:0];
         res_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAST; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (ready[1]) begin
            v_ff[1] <= issue.valid;
         end
         for (int k = 2; k <= LAST; k++) begin
            if (ready[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         x_ff[1]   <= issue.x;
         sel_ff[1] <= issue.sel;
      end
      for (int k = 2; k <= NC; k++) begin
         if (ready[k]) begin
            x_ff[k]   <= x_ff[k-1];
            sel_ff[k] <= sel_ff[k-1];
            pw_ff[k]  <= pw_in[k-1];
            row_ff[k] <= st_row[k-1];
            acc_ff[k] <= acc_in[k-1];
            hi_ff[k]  <= hi_in[k-1];
            lo_ff[k]  <= lo_in[k-1];
         end
      end
      if (ready[NC+1]) begin
         sum_ff       <= acc_in[NC];
         sel_ff[NC+1] <= sel_ff[NC];
      end
      if (ready[LAST]) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = v_ff[LAST];
   assign res       = res_ff;

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.saturated) |->
         (res.value == pwe_pkg::ACC_VALUE_MAX[pwe_pkg::COEFF_W-1:0] ||
          res.value == pwe_pkg::ACC_VALUE_MIN[pwe_pkg::COEFF_W-1:0]))
      else $error("saturated result does not hold a range limit");

   a_interval_range: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (32'(res.interval) < pwe_pkg::NUM_INTERVALS))
      else $error("chosen interval outside the table");

   a_power_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] |-> (pw_ff[2] <= pwe_pkg::ARG_ONE))
      else $error("power of the argument exceeds one");

   a_free_output_takes: assert property (@(posedge clock) disable iff (reset)
      !v_ff[LAST] |-> issue_ready)
      else $error("pipeline refuses a word while its output is empty");

endmodule

`default_nettype wire

### rtl/piecewise_poly_evaluator.sv
// Top level of the piecewise polynomial evaluator: request decode, table and pipeline.
//
// Use: the req_ channel carries two kinds of word. A load word (req_type = REQ_LOAD)
// writes one coefficient into the table at (req_load_interval, req_load_power) and gives
// no result; loads outside the table are dropped. An evaluate word clamps req_argument
// to 1.0, picks interval floor(x*35) (1.0 takes the last one), reads that row and
// returns its polynomial on the rsp_ channel, with the interval and a saturation flag.
// Throughput: one word per cycle of either kind while req_stall is low. Stages 1 to
// NUM_COEFFS-1 each hold one multiplier-sized step of the power chain and of one term;
// the stages after them add up the terms, saturate and hold the output. The table row
// is read at the edge that accepts the evaluate word, so any load accepted before it
// is already visible.
// Reset clears all pipeline valids; the table keeps whatever it held and must be loaded
// before an interval is evaluated.
// When rsp_stall is high the result waits in the output register; empty stages still
// take new words, and req_stall rises only once every stage holds a word.
`default_nettype none

module piecewise_poly_evaluator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_type,
   input  wire logic [pwe_pkg::INTERVAL_W-1:0]    req_load_interval,
   input  wire logic [pwe_pkg::POWER_W-1:0]       req_load_power,
   input  wire logic signed [pwe_pkg::COEFF_W-1:0] req_coeff_value,
   input  wire logic [pwe_pkg::ARG_W-1:0]         req_argument,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [pwe_pkg::COEFF_W-1:0]     rsp_value,
   output logic [pwe_pkg::INTERVAL_W-1:0]         rsp_chosen_interval,
   output logic                                   rsp_saturated
);

   logic                               accept;
   logic                               is_eval;
   logic                               load_in_range;
   logic                               wr_en;
   logic [pwe_pkg::ARG_W-1:0]          x_clamped;
   logic [pwe_pkg::IDX_PROD_W-1:0]     idx_prod;
   logic [pwe_pkg::IDX_RAW_W-1:0]      idx_raw;
   logic [pwe_pkg::ROW_AW-1:0]         sel;
   logic                               issue_ready;
   pwe_pkg::issue_type                 issue;
   pwe_pkg::coeff_row_type             row_data;
   pwe_pkg::result_type                res;

   assign req_stall = !issue_ready;
   assign accept    = req_valid && issue_ready;
   assign is_eval   = (req_type == pwe_pkg::REQ_EVAL);

   assign load_in_range = (32'(req_load_interval) < pwe_pkg::NUM_INTERVALS)
                          && (32'(req_load_power) < pwe_pkg::NUM_COEFFS);
   assign wr_en = accept && !is_eval && load_in_range;

   always_comb begin
      if (req_argument > pwe_pkg::ARG_ONE) begin
         x_clamped = pwe_pkg::ARG_ONE;
      end else begin
         x_clamped = req_argument;
      end
      idx_prod = pwe_pkg::IDX_PROD_W'(x_clamped)
                 * pwe_pkg::IDX_PROD_W'(pwe_pkg::NUM_INTERVALS);
      idx_raw  = idx_prod[pwe_pkg::IDX_PROD_W-1:pwe_pkg::FRAC_W];
      // Only a clamped argument of exactly one lands past the last interval.
      if (idx_raw >= pwe_pkg::IDX_RAW_W'(pwe_pkg::NUM_INTERVALS)) begin
         sel = pwe_pkg::ROW_AW'(pwe_pkg::NUM_INTERVALS - 1);
      end else begin
         sel = pwe_pkg::ROW_AW'(idx_raw);
      end
   end

   always_comb begin
      issue.valid = req_valid && is_eval;
      issue.sel   = sel;
      issue.x     = x_clamped;
   end

   pwe_coeff_mem u_coeff_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (pwe_pkg::ROW_AW'(req_load_interval)),
      .wr_lane (pwe_pkg::LANE_W'(req_load_power)),
      .wr_data (req_coeff_value),
      .rd_en   (issue_ready),
      .rd_row  (sel),
      .rd_data (row_data)
   );

   pwe_eval_pipe u_eval_pipe (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .issue_ready (issue_ready),
      .row_data    (row_data),
      .res_valid   (rsp_valid),
      .res_stall   (rsp_stall),
      .res         (res)
   );

   assign rsp_value           = res.value;
   assign rsp_chosen_interval = res.interval;
   assign rsp_saturated       = res.saturated;

endmodule

`default_nettype wire

### tb/tb_piecewise_poly_evaluator.sv
// Self-checking testbench for the piecewise polynomial evaluator.
module tb_piecewise_poly_evaluator;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      pwe_pkg::req_kind_type              kind;
      logic [pwe_pkg::INTERVAL_W-1:0]     intv;
      logic [pwe_pkg::POWER_W-1:0]        pwr;
      logic signed [pwe_pkg::COEFF_W-1:0] coeff;
      logic [pwe_pkg::ARG_W-1:0]          arg;
      logic                               typed;
      pwe_pkg::result_type                want;
   } stim_row_type;

   localparam logic signed [pwe_pkg::COEFF_W-1:0] CMAX =
      {1'b0, {(pwe_pkg::COEFF_W-1){1'b1}}};
   localparam logic signed [pwe_pkg::COEFF_W-1:0] CMIN =
      {1'b1, {(pwe_pkg::COEFF_W-1){1'b0}}};
   localparam logic signed [pwe_pkg::COEFF_W-1:0] CONE =
      pwe_pkg::COEFF_W'(1) << pwe_pkg::FRAC_W;
   localparam logic [pwe_pkg::ARG_W-1:0] X_TOP   = {pwe_pkg::ARG_W{1'b1}};
   localparam logic [pwe_pkg::ARG_W-1:0] X_EDGE0 = 25'd479349;
   localparam pwe_pkg::result_type NONE = '0;
   localparam logic signed [79:0] SUM_TOP = (80'sd1 <<< (pwe_pkg::COEFF_W - 1)) - 80'sd1;
   localparam logic signed [79:0] SUM_BOT = -(80'sd1 <<< (pwe_pkg::COEFF_W - 1));
   localparam int TOTAL_WORDS = 700;
   localparam int HOLD_CYCLES = 200;

   // Row 34 is filled with the largest coefficient and row 0 with the smallest, so
   // the clamped and boundary arguments give results that can be read off directly.
   stim_row_type directed_words [22] = '{
      '{pwe_pkg::REQ_LOAD, 6'd34, 3'd0, CMAX, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd34, 3'd1, CMAX, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd34, 3'd2, CMAX, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd34, 3'd3, CMAX, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd34, 3'd4, CMAX, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd34, 3'd5, CMAX, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_EVAL, 6'd0, 3'd0, '0, pwe_pkg::ARG_ONE, 1'b1, '{CMAX, 6'd34, 1'b1}},
      '{pwe_pkg::REQ_EVAL, 6'd63, 3'd7, CMIN, X_TOP, 1'b1, '{CMAX, 6'd34, 1'b1}},
      '{pwe_pkg::REQ_EVAL, 6'd0, 3'd0, '0, pwe_pkg::ARG_ONE + 25'd1, 1'b1,
        '{CMAX, 6'd34, 1'b1}},
      '{pwe_pkg::REQ_EVAL, 6'd0, 3'd0, '0, pwe_pkg::ARG_ONE - 25'd1, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd0, 3'd0, CMIN, X_TOP, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd0, 3'd1, CMIN, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd0, 3'd2, CMIN, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd0, 3'd3, CMIN, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd0, 3'd4, CMIN, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd0, 3'd5, CMIN, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd35, 3'd0, CONE, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd63, 3'd7, CMAX, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd0, 3'd6, CONE, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_LOAD, 6'd34, 3'd7, CMIN, '0, 1'b0, NONE},
      '{pwe_pkg::REQ_EVAL, 6'd0, 3'd0, '0, '0, 1'b1, '{CMIN, 6'd0, 1'b0}},
      '{pwe_pkg::REQ_EVAL, 6'd0, 3'd0, '0, X_EDGE0, 1'b1, '{CMIN, 6'd0, 1'b1}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = pwe_pkg::REQ_LOAD;
   logic [pwe_pkg::INTERVAL_W-1:0] req_load_interval = '0;
   logic [pwe_pkg::POWER_W-1:0] req_load_power = '0;
   logic signed [pwe_pkg::COEFF_W-1:0] req_coeff_value = '0;
   logic [pwe_pkg::ARG_W-1:0] req_argument = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [pwe_pkg::COEFF_W-1:0] rsp_value;
   logic [pwe_pkg::INTERVAL_W-1:0] rsp_chosen_interval;
   logic rsp_saturated;

   logic typed_on = 1'b0;
   pwe_pkg::result_type typed_want = '0;
   logic signed [pwe_pkg::COEFF_W-1:0]
      coeff_mirror [pwe_pkg::NUM_INTERVALS][pwe_pkg::NUM_COEFFS] = '{default: '0};
   pwe_pkg::result_type pending_results [$];
   pwe_pkg::result_type oldest;
   int mismatch_count = 0;
   int burst_left = 0;
   bit hold_wanted = 1'b0;

   piecewise_poly_evaluator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_load_interval(req_load_interval), .req_load_power(req_load_power),
      .req_coeff_value(req_coeff_value), .req_argument(req_argument),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value),
      .rsp_chosen_interval(rsp_chosen_interval), .rsp_saturated(rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the polynomial value for one evaluate word from the mirrored table.
   function automatic void predict_response(input logic [pwe_pkg::ARG_W-1:0] arg_in);
      logic [pwe_pkg::ARG_W-1:0] x;
      logic [pwe_pkg::ARG_W-1:0] pw;
      logic [2*pwe_pkg::ARG_W-1:0] pw_wide;
      logic signed [79:0] sum;
      logic signed [79:0] cw;
      logic signed [79:0] pw80;
      int sel;
      pwe_pkg::result_type r;
      x = (arg_in > pwe_pkg::ARG_ONE) ? pwe_pkg::ARG_ONE : arg_in;
      sel = int'((64'(x) * pwe_pkg::NUM_INTERVALS) >> pwe_pkg::FRAC_W);
      if (sel >= pwe_pkg::NUM_INTERVALS) sel = pwe_pkg::NUM_INTERVALS - 1;
      sum = coeff_mirror[sel][0];
      pw = x;
      for (int i = 1; i < pwe_pkg::NUM_COEFFS; i++) begin
         cw = coeff_mirror[sel][i];
         pw80 = {{(80-pwe_pkg::ARG_W){1'b0}}, pw};
         sum = sum + ((cw * pw80) >>> pwe_pkg::FRAC_W);
         pw_wide = pw * x;
         pw = pw_wide[pwe_pkg::FRAC_W +: pwe_pkg::ARG_W];
      end
      r.saturated = 1'b1;
      if (sum > SUM_TOP) sum = SUM_TOP;
      else if (sum < SUM_BOT) sum = SUM_BOT;
      else r.saturated = 1'b0;
      r.value = sum[pwe_pkg::COEFF_W-1:0];
      r.interval = pwe_pkg::INTERVAL_W'(sel);
      pending_results.push_back(r);
   endfunction

   // Mostly small coefficients, so that most sums stay in range.
   function automatic logic signed [pwe_pkg::COEFF_W-1:0] draw_coeff();
      longint r;
      int pick;
      r = {$urandom(), $urandom()};
      pick = $urandom_range(0, 9);
      if (pick < 7) return pwe_pkg::COEFF_W'(r >>> 37);
      else if (pick < 9) return pwe_pkg::COEFF_W'(r >>> 23);
      return pwe_pkg::COEFF_W'(r);
   endfunction

   task automatic offer_word(input stim_row_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= w.kind;
      req_load_interval <= w.intv;
      req_load_power <= w.pwr;
      req_coeff_value <= w.coeff;
      req_argument <= w.arg;
      typed_on <= w.typed;
      typed_want <= w.want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Checks results and predicts accepted words in one process, so the order of the
   // two is fixed.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result word with none expected: value %0d interval %0d",
                      rsp_value, rsp_chosen_interval);
               mismatch_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_value !== oldest.value) begin
                  $error("value: expected %0d, got %0d", oldest.value, rsp_value);
                  mismatch_count++;
               end
               if (rsp_chosen_interval !== oldest.interval) begin
                  $error("chosen_interval: expected %0d, got %0d",
                         oldest.interval, rsp_chosen_interval);
                  mismatch_count++;
               end
               if (rsp_saturated !== oldest.saturated) begin
                  $error("saturated: expected %0d, got %0d",
                         oldest.saturated, rsp_saturated);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == pwe_pkg::REQ_EVAL) begin
               if (typed_on) pending_results.push_back(typed_want);
               else predict_response(req_argument);
            end else if (req_load_interval < pwe_pkg::NUM_INTERVALS
                         && req_load_power < pwe_pkg::NUM_COEFFS) begin
               coeff_mirror[req_load_interval][req_load_power] = req_coeff_value;
            end
         end
      end
   end

   // Receiver: stretches of no stall, light stall and heavy stall, plus one long
   // hold-off once the random stream is running.
   initial begin
      int stretch;
      int mode;
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end
         stretch = $urandom_range(10, 80);
         mode = $urandom_range(0, 2);
         repeat (stretch) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_piecewise_poly_evaluator: done, errors");
      $finish;
   end

   initial begin
      stim_row_type w;
      int counted;
      int pick;
      int k;
      int edge_x;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) offer_word(directed_words[i]);

      // Every table entry is written before any random evaluate word is sent.
      counted = 0;
      for (int iv = 0; iv < pwe_pkg::NUM_INTERVALS; iv++) begin
         for (int p = 0; p < pwe_pkg::NUM_COEFFS; p++) begin
            w = '0;
            w.kind = pwe_pkg::REQ_LOAD;
            w.intv = pwe_pkg::INTERVAL_W'(iv);
            w.pwr = pwe_pkg::POWER_W'(p);
            w.coeff = draw_coeff();
            w.arg = pwe_pkg::ARG_W'($urandom_range(0, 2**pwe_pkg::ARG_W - 1));
            offer_word(w);
            counted++;
         end
      end

      hold_wanted = 1'b1;
      while (counted < TOTAL_WORDS) begin
         w = '0;
         w.intv = pwe_pkg::INTERVAL_W'($urandom_range(0, 63));
         w.pwr = pwe_pkg::POWER_W'($urandom_range(0, 7));
         w.coeff = draw_coeff();
         w.arg = pwe_pkg::ARG_W'($urandom_range(0, 2**pwe_pkg::ARG_W - 1));
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            w.kind = pwe_pkg::REQ_EVAL;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               w.arg = pwe_pkg::ARG_W'($urandom_range(0, 1 << pwe_pkg::FRAC_W));
            end else if (pick < 75) begin
               // Around the lower edge of an interval.
               k = $urandom_range(1, pwe_pkg::NUM_INTERVALS - 1);
               edge_x = (k * (1 << pwe_pkg::FRAC_W) + pwe_pkg::NUM_INTERVALS - 1)
                        / pwe_pkg::NUM_INTERVALS;
               w.arg = pwe_pkg::ARG_W'(edge_x - 1 + $urandom_range(0, 2));
            end else if (pick < 85) begin
               w.arg = pwe_pkg::ARG_W'($urandom_range((1 << pwe_pkg::FRAC_W) + 1,
                                                      2**pwe_pkg::ARG_W - 1));
            end else if (pick < 90) begin
               w.arg = pwe_pkg::ARG_ONE;
            end else begin
               w.arg = pwe_pkg::ARG_W'($urandom_range(0, 255));
            end
         end else if (pick < 90) begin
            w.kind = pwe_pkg::REQ_LOAD;
            w.intv = pwe_pkg::INTERVAL_W'($urandom_range(0, pwe_pkg::NUM_INTERVALS - 1));
            w.pwr = pwe_pkg::POWER_W'($urandom_range(0, pwe_pkg::NUM_COEFFS - 1));
         end else begin
            // A load outside the table, which the block drops.
            w.kind = pwe_pkg::REQ_LOAD;
            if ($urandom_range(0, 1) == 0) begin
               w.intv = pwe_pkg::INTERVAL_W'($urandom_range(pwe_pkg::NUM_INTERVALS, 63));
            end else begin
               w.intv = pwe_pkg::INTERVAL_W'($urandom_range(0, pwe_pkg::NUM_INTERVALS - 1));
               w.pwr = pwe_pkg::POWER_W'($urandom_range(pwe_pkg::NUM_COEFFS, 7));
            end
         end
         offer_word(w);
         counted++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_piecewise_poly_evaluator: done, clean");
      end else begin
         $display("tb_piecewise_poly_evaluator: done, errors");
      end
      $finish;
   end

endmodule
